// ===== src/ifr_pkg.sv =====
// Shared types and constants of the 5x5 replicate-border image filter.
package ifr_pkg;

  // Pixel, weight and accumulator widths.
  localparam int PIX_W = 8;
  localparam int WT_W = 8;
  localparam int WSUM_W = 13;
  localparam int ACC_W = 21;
  localparam int NUM_TAPS = 25;
  localparam int WIN_DIM = 5;
  localparam int AVG_DIV = 25;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_WIDTH = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_MASK0 = 3'd3;
  localparam logic [2:0] REG_MASK1 = 3'd4;
  localparam logic [2:0] REG_MASK2 = 3'd5;
  localparam logic [2:0] REG_MASK3 = 3'd6;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_SETUP  = 8'b0000_0100,
    S_DIVK   = 8'b0000_1000,
    S_TAPS   = 8'b0001_0000,
    S_ASTART = 8'b0010_0000,
    S_DIVA   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

// ===== src/ifr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module ifr_div #(
  parameter int N = 23
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient,
  output logic [N-1:0] remainder
);

  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [N-1:0]  dvs;
  logic [N:0]    rsh;
  logic          take;

  // Shift the next dividend bit into the partial remainder and compare.
  always_comb begin
    rsh = {remainder, quotient[N-1]};
    take = (rsh >= {1'b0, dvs});
  end

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in from the right as the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quotient <= {quotient[N-2:0], take};
      if (take) begin
        remainder <= N'(rsh - {1'b0, dvs});
      end else begin
        remainder <= rsh[N-1:0];
      end
    end
  end

endmodule

// ===== src/ifr_lmem.sv =====
// Line store: one write port and one registered read port.
module ifr_lmem #(
  parameter int DEPTH = 4104,
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/image_filter_5x5_replicate_border_unit.sv =====
// Top level of the 5x5 replicate-border image filter with its sequencer.
// An item that returns no result passes through the load, setup and done states;
// one with a result also waits on the shared divider, used once for the output
// position and, unless zero_weight is raised, once for the quotient, and on the 25 taps.
// One item is in work at a time; a finished result waits in the output register.
// Reset (synchronous, active high) clears control state and restores registers.
module image_filter_5x5_replicate_border_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        drain,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  filtered,
  output logic        zero_weight,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  import ifr_pkg::*;

  localparam int DEPTH = 4 * MAX_WIDTH + 8;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(4 * MAX_WIDTH + 5);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
  localparam int DIV_W = (CNT_W > ACC_W) ? CNT_W : ACC_W;
  localparam int RW = $clog2(MAX_HEIGHT + 5);
  localparam int CW = $clog2(MAX_WIDTH + 5);

  // Configuration registers.
  logic        mode;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [63:0] mask_word0;
  logic [63:0] mask_word1;
  logic [63:0] mask_word2;
  logic [7:0]  mask_word3;

  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      frame_width <= 11'd1024;
      frame_height <= 13'd1;
      mask_word0 <= '0;
      mask_word1 <= '0;
      mask_word2 <= '0;
      mask_word3 <= '0;
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        REG_MODE:   mode <= pwdata[0];
        REG_WIDTH:  frame_width <= pwdata[10:0];
        REG_HEIGHT: frame_height <= pwdata[12:0];
        REG_MASK0:  mask_word0 <= pwdata;
        REG_MASK1:  mask_word1 <= pwdata;
        REG_MASK2:  mask_word2 <= pwdata;
        REG_MASK3:  mask_word3 <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[5:3])
      REG_MODE:   prdata = {63'd0, mode};
      REG_WIDTH:  prdata = {53'd0, frame_width};
      REG_HEIGHT: prdata = {51'd0, frame_height};
      REG_MASK0:  prdata = mask_word0;
      REG_MASK1:  prdata = mask_word1;
      REG_MASK2:  prdata = mask_word2;
      REG_MASK3:  prdata = {56'd0, mask_word3};
      default:    prdata = '0;
    endcase
  end

  // Effective geometry: zero acts as one, oversize values saturate.
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
  end

  // Frame sizes, registered to keep the multiplier off the sequencer path.
  logic [CNT_W-1:0] npix;
  logic [CNT_W-1:0] lead;
  logic [CNT_W-1:0] total;
  always_ff @(posedge clk) begin
    npix <= CNT_W'(eff_w * eff_h);
    lead <= CNT_W'({eff_w, 1'b0}) + CNT_W'(2);
    total <= CNT_W'(eff_w * eff_h) + CNT_W'({eff_w, 1'b0}) + CNT_W'(2);
  end

  // Sequencer and per-item registers.
  state_t           state;
  logic [CNT_W-1:0] item_count;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] t_r;
  logic [AW-1:0]    wr_r;
  logic [7:0]       pix_r;
  logic             has_res;
  logic             fe_r;
  logic [RW-1:0]    r_pos;
  logic [CW-1:0]    c_pos;
  logic [2:0]       ty;
  logic [2:0]       tx;
  logic [4:0]       tap;
  logic             mac_v;
  logic [4:0]       mac_idx;
  logic [ACC_W-1:0] acc;
  logic [WSUM_W-1:0] ws;
  logic [7:0]       filt_r;
  logic             zw_r;

  logic [CNT_W-1:0] k_val;
  logic [CNT_W:0]   t_inc;
  logic             load_out;

  assign k_val = t_r - lead;
  assign t_inc = {1'b0, t_r} + 1'b1;
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && has_res && (!out_valid || out_ready);

  // Shared divider: output position first, then the filter quotient.
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] div_r;
  logic             ws_zero;

  assign ws_zero = mode && (ws == '0);
  always_comb begin
    div_start = 1'b0;
    div_num = DIV_W'(acc);
    div_den = mode ? DIV_W'(ws) : DIV_W'(AVG_DIV);
    if (state == S_SETUP) begin
      div_num = DIV_W'(k_val);
      div_den = DIV_W'(eff_w);
      div_start = (t_r >= lead);
    end else if (state == S_ASTART) begin
      div_start = !ws_zero;
    end
  end

  ifr_div #(.N(DIV_W)) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_num),
    .divisor(div_den),
    .done(div_done),
    .quotient(div_q),
    .remainder(div_r)
  );

  // Window address: distance back from the newest pixel, clamped at the borders.
  // The newest pixel sits two rows and two columns past the window center.
  logic [RW:0]   rp;
  logic [RW:0]   rhi;
  logic [RW:0]   rcl;
  logic [CW:0]   cp;
  logic [CW:0]   chi;
  logic [CW:0]   ccl;
  logic [2:0]    my;
  logic [2:0]    mx;
  logic [DW-1:0] rowoff;
  logic [DW-1:0] back_dist;
  logic [AW-1:0] raddr;
  logic          mem_we;

  always_comb begin
    rp = (RW+1)'(r_pos) + (RW+1)'(ty);
    rhi = (RW+1)'(eff_h) + (RW+1)'(1);
    if (rp < (RW+1)'(2)) begin
      rcl = (RW+1)'(2);
    end else if (rp > rhi) begin
      rcl = rhi;
    end else begin
      rcl = rp;
    end
    my = 3'((RW+1)'(r_pos) + (RW+1)'(4) - rcl);
    cp = (CW+1)'(c_pos) + (CW+1)'(tx);
    chi = (CW+1)'(eff_w) + (CW+1)'(1);
    if (cp < (CW+1)'(2)) begin
      ccl = (CW+1)'(2);
    end else if (cp > chi) begin
      ccl = chi;
    end else begin
      ccl = cp;
    end
    mx = 3'((CW+1)'(c_pos) + (CW+1)'(4) - ccl);
    unique case (my)
      3'd0:    rowoff = '0;
      3'd1:    rowoff = DW'(eff_w);
      3'd2:    rowoff = DW'(eff_w) << 1;
      3'd3:    rowoff = DW'(eff_w) + (DW'(eff_w) << 1);
      default: rowoff = DW'(eff_w) << 2;
    endcase
    back_dist = rowoff + DW'(mx);
    if (wr_r >= AW'(back_dist)) begin
      raddr = wr_r - AW'(back_dist);
    end else begin
      raddr = AW'((AW+1)'(wr_r) + (AW+1)'(DEPTH) - (AW+1)'(back_dist));
    end
  end

  assign mem_we = (state == S_SETUP) && (t_r < npix);

  logic [7:0] rdata;
  ifr_lmem #(.DEPTH(DEPTH), .AW(AW)) u_lmem (
    .clk(clk),
    .we(mem_we),
    .waddr(wr_r),
    .wdata(pix_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Weight of the tap being accumulated.
  logic [63:0] wsel;
  logic [7:0]  wt;
  always_comb begin
    unique case (mac_idx[4:3])
      2'd0:    wsel = mask_word0;
      2'd1:    wsel = mask_word1;
      2'd2:    wsel = mask_word2;
      default: wsel = {56'd0, mask_word3};
    endcase
    wt = wsel[{mac_idx[2:0], 3'b000} +: 8];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      item_count <= '0;
      wr_addr <= '0;
      mac_v <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pix_r <= drain ? 8'd0 : pixel;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (item_count >= total) begin
            t_r <= '0;
            wr_r <= '0;
          end else begin
            t_r <= item_count;
            wr_r <= wr_addr;
          end
          state <= S_SETUP;
        end
        S_SETUP: begin
          has_res <= (t_r >= lead);
          fe_r <= (k_val == npix - 1'b1);
          state <= (t_r >= lead) ? S_DIVK : S_DONE;
        end
        S_DIVK: begin
          if (div_done) begin
            r_pos <= RW'(div_q);
            c_pos <= CW'(div_r);
            ty <= '0;
            tx <= '0;
            tap <= '0;
            acc <= '0;
            ws <= '0;
            mac_v <= 1'b0;
            state <= S_TAPS;
          end
        end
        S_TAPS: begin
          // Issue one read per cycle and accumulate the previous tap.
          if (mac_v) begin
            if (mode) begin
              acc <= acc + ACC_W'(rdata * wt);
            end else begin
              acc <= acc + ACC_W'(rdata);
            end
            ws <= ws + WSUM_W'(wt);
          end
          if (tap == 5'(NUM_TAPS)) begin
            mac_v <= 1'b0;
            state <= S_ASTART;
          end else begin
            mac_v <= 1'b1;
            mac_idx <= tap;
            tap <= tap + 1'b1;
            if (tx == 3'(WIN_DIM - 1)) begin
              tx <= '0;
              ty <= ty + 1'b1;
            end else begin
              tx <= tx + 1'b1;
            end
          end
        end
        S_ASTART: begin
          if (ws_zero) begin
            filt_r <= '0;
            zw_r <= 1'b1;
            state <= S_DONE;
          end else begin
            zw_r <= 1'b0;
            state <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_done) begin
            filt_r <= div_q[7:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!has_res || load_out) begin
            if (t_inc >= (CNT_W+1)'(total)) begin
              item_count <= '0;
              wr_addr <= '0;
            end else begin
              item_count <= CNT_W'(t_inc);
              wr_addr <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered <= filt_r;
      zero_weight <= zw_r;
      frame_end <= fe_r;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the 5x5 replicate-border image filter.
`timescale 1ns / 100ps

module testbench;
  import ifr_pkg::*;

  localparam int STORE_DEPTH = 4 * 1024 + 8;
  localparam int RANDOM_ITEMS = 1700;
  localparam int TALL_ITEMS = 150;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [7:0] filt;
    logic       zw;
    logic       fe;
  } pix_result_t;

  typedef struct {
    logic [7:0]  px;
    logic        dr;
    bit          typed;
    pix_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel;
  logic        drain;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  filtered;
  logic        zero_weight;
  logic        frame_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  image_filter_5x5_replicate_border_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel), .drain(drain),
    .out_valid(out_valid), .out_ready(out_ready), .filtered(filtered),
    .zero_weight(zero_weight), .frame_end(frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the filter: configuration, pixel store and frame position.
  logic        flt_mode;
  logic [10:0] flt_width;
  logic [12:0] flt_height;
  logic [7:0]  flt_weight [NUM_TAPS];
  logic [12:0] flt_wsum;
  logic [7:0]  pix_store [STORE_DEPTH];
  int unsigned frame_pos;

  pix_result_t expected_px [$];
  int          mismatches;
  int          results_seen;
  int          items_sent;
  int          frames_run;
  int          out_hold;
  bit          no_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Work out the result, if any, that one accepted item causes.
  function automatic bit filter_item(input logic [7:0] px, input logic dr,
                                     output pix_result_t res);
    int unsigned w, h, npix, lead, total, t, k, r, c, idx;
    int          rr, cc, dy, dx, z;
    int unsigned acc;
    w = (flt_width == 0) ? 1 : ((flt_width > 1024) ? 1024 : flt_width);
    h = (flt_height == 0) ? 1 : ((flt_height > 4096) ? 4096 : flt_height);
    npix = w * h;
    lead = 2 * w + 2;
    total = npix + lead;
    res = '0;
    if (frame_pos >= total) frame_pos = 0;
    t = frame_pos;
    frame_pos = (t + 1 >= total) ? 0 : t + 1;
    if (t < npix) pix_store[t % STORE_DEPTH] = dr ? 8'd0 : px;
    if (t < lead) return 1'b0;
    k = t - lead;
    r = k / w;
    c = k % w;
    acc = 0;
    z = 0;
    for (dy = -2; dy <= 2; dy++) begin
      rr = int'(r) + dy;
      rr = (rr < 0) ? 0 : ((rr > int'(h) - 1) ? int'(h) - 1 : rr);
      for (dx = -2; dx <= 2; dx++) begin
        cc = int'(c) + dx;
        cc = (cc < 0) ? 0 : ((cc > int'(w) - 1) ? int'(w) - 1 : cc);
        idx = (rr * w + cc) % STORE_DEPTH;
        acc += flt_mode ? pix_store[idx] * flt_weight[z] : pix_store[idx];
        z++;
      end
    end
    if (!flt_mode) begin
      res.filt = 8'(acc / AVG_DIV);
    end else if (flt_wsum == 0) begin
      res.zw = 1'b1;
    end else begin
      res.filt = 8'(acc / flt_wsum);
    end
    res.fe = (k == npix - 1);
    return 1'b1;
  endfunction

  // Register write over the configuration port; the shadow follows.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    int s;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_MODE:   flt_mode = value[0];
      REG_WIDTH:  flt_width = value[10:0];
      REG_HEIGHT: flt_height = value[12:0];
      REG_MASK0:  for (int i = 0; i < 8; i++) flt_weight[i] = value[8*i +: 8];
      REG_MASK1:  for (int i = 0; i < 8; i++) flt_weight[8+i] = value[8*i +: 8];
      REG_MASK2:  for (int i = 0; i < 8; i++) flt_weight[16+i] = value[8*i +: 8];
      REG_MASK3:  flt_weight[24] = value[7:0];
      default: ;
    endcase
    s = 0;
    for (int i = 0; i < NUM_TAPS; i++) s += flt_weight[i];
    flt_wsum = 13'(s);
  endtask

  // Offer one item after a random gap and record what it should produce.
  task automatic send_item(input logic [7:0] px, input logic dr, input bit typed,
                           input pix_result_t typed_res);
    int          gap;
    pix_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel = px;
    drain = dr;
    do @(posedge clk); while (!in_ready);
    if (filter_item(px, dr, res)) expected_px.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  // Let every outstanding result come out, then let the block go idle.
  task automatic settle();
    in_valid = 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One whole frame at the current geometry; pause marks the mid-frame hold.
  task automatic run_frame(input bit pause);
    int unsigned w, h, npix, lead;
    logic [7:0]  px;
    w = (flt_width == 0) ? 1 : ((flt_width > 1024) ? 1024 : flt_width);
    h = (flt_height == 0) ? 1 : ((flt_height > 4096) ? 4096 : flt_height);
    npix = w * h;
    lead = 2 * w + 2;
    for (int unsigned i = 0; i < npix + lead; i++) begin
      case ($urandom_range(0, 9))
        0: px = 8'd0;
        1: px = 8'hFF;
        default: px = 8'($urandom);
      endcase
      if (pause && i == npix / 2 + lead) begin
        in_valid = 1'b0;
        while (expected_px.size() != 0) @(negedge clk);
      end
      if (i < npix) send_item(px, $urandom_range(0, 19) == 0, 1'b0, '0);
      else send_item(px, $urandom_range(0, 4) != 0, 1'b0, '0);
    end
    frames_run++;
  endtask

  // The head of a frame only; a smaller geometry written later starts a new frame.
  task automatic run_part(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(8'($urandom), 1'b0, 1'b0, '0);
  endtask

  // Output side: random stalls after each item, none while no_idle is set.
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (out_hold > 0) begin
      out_ready = 1'b0;
      out_hold--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    pix_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: filtered=%0d zero_weight=%0b frame_end=%0b",
                   filtered, zero_weight, frame_end);
      end else begin
        want = expected_px.pop_front();
        if (filtered !== want.filt || zero_weight !== want.zw || frame_end !== want.fe) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b", results_seen,
                     want.filt, want.zw, want.fe, filtered, zero_weight, frame_end);
        end
      end
      out_hold = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  // Overall time limit.
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus: directed frames, extremes of geometry and mask, then random frames.
  initial begin
    stim_row_t   stim_rows [$];
    pix_result_t none;
    logic [7:0]  seed_px [4];
    int          rand_start;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel = '0;
    drain = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    out_hold = 0;
    no_idle = 1'b0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    frames_run = 0;
    flt_mode = 1'b0;
    flt_width = 11'd1024;
    flt_height = 13'd1;
    flt_wsum = '0;
    frame_pos = 0;
    for (int i = 0; i < NUM_TAPS; i++) flt_weight[i] = '0;
    for (int i = 0; i < STORE_DEPTH; i++) pix_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // One-pixel frames: every tap is that pixel, so the average returns it.
    // A drain bit during the pixel phase stores zero.
    write_reg(REG_WIDTH, 64'd1);
    write_reg(REG_HEIGHT, 64'd1);
    seed_px = '{8'hFF, 8'h00, 8'hC8, 8'h80};
    for (int f = 0; f < 4; f++) begin
      stim_rows.push_back('{seed_px[f], f == 2, 1'b0, none});
      stim_rows.push_back('{8'h5A, 1'b1, 1'b0, none});
      stim_rows.push_back('{8'hA5, 1'b0, 1'b0, none});
      stim_rows.push_back('{8'h00, 1'b1, 1'b0, none});
      stim_rows.push_back('{8'hFF, 1'b1, 1'b1, '{(f == 2) ? 8'h00 : seed_px[f], 1'b0, 1'b1}});
    end
    foreach (stim_rows[i]) send_item(stim_rows[i].px, stim_rows[i].dr, stim_rows[i].typed,
                                     stim_rows[i].res);
    settle();

    // Weighted mode with an all-zero mask raises the flag.
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_WIDTH, 64'd3);
    write_reg(REG_HEIGHT, 64'd2);
    run_frame(1'b0);
    settle();

    // Largest weights, with stray upper bits on the last mask word.
    write_reg(REG_MASK0, '1);
    write_reg(REG_MASK1, '1);
    write_reg(REG_MASK2, '1);
    write_reg(REG_MASK3, '1);
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd0);
    run_frame(1'b0);
    settle();

    // Oversize height on a one-pixel column, both sides flat out; only the head
    // of the frame is sent, and the next smaller geometry restarts the frame.
    no_idle = 1'b1;
    write_reg(REG_MODE, 64'd0);
    write_reg(REG_WIDTH, 64'd1);
    write_reg(REG_HEIGHT, 64'd8191);
    run_part(TALL_ITEMS);
    settle();
    no_idle = 1'b0;

    // Random frames with random geometry, mode and mask.
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      write_reg(REG_MODE, 64'($urandom_range(0, 1)));
      write_reg(REG_WIDTH, 64'($urandom_range(0, 12)));
      write_reg(REG_HEIGHT, 64'($urandom_range(0, 8)));
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_MASK0, '0);
        write_reg(REG_MASK1, '0);
        write_reg(REG_MASK2, '0);
        write_reg(REG_MASK3, '0);
      end else begin
        write_reg(REG_MASK0, {$urandom, $urandom});
        write_reg(REG_MASK1, {$urandom, $urandom});
        write_reg(REG_MASK2, {$urandom, $urandom});
        write_reg(REG_MASK3, {$urandom, $urandom});
      end
      no_idle = ($urandom_range(0, 5) == 0);
      run_frame(frames_run == 12);
      if ($urandom_range(0, 1)) run_frame(1'b0);
      settle();
    end
    no_idle = 1'b0;
    settle();

    $display("Ran %0d items in %0d frames, %0d results checked.",
             items_sent, frames_run, results_seen);
    $display("Covered both modes, zero and full masks, zero and oversize geometry,",
             " and a frame restarted by a smaller geometry.");
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
